// ----- rtl/core/fa_pkg.sv -----
`default_nettype none

package fa_pkg;

    // Frame index space and frame counter widths
    localparam int unsigned MAX_FRAMES = 256;
    localparam int unsigned FRAME_W    = 8;
    localparam int unsigned CNT_W      = 9;
    localparam int unsigned OWNER_W    = 16;

    // Request codes
    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } status_t;

    // One result item
    typedef struct packed {
        status_t              status;
        logic [FRAME_W-1:0]   granted_frame;
        logic [OWNER_W-1:0]   owner_out;
        logic                 owner_present;
        logic                 free_available;
    } res_t;

    // Write command to the free stack memory
    typedef struct packed {
        logic                 en;
        logic [FRAME_W-1:0]   addr;
        logic [FRAME_W-1:0]   data;
    } stk_wr_t;

    // Write command to the owner memory
    typedef struct packed {
        logic                 en;
        logic [FRAME_W-1:0]   addr;
        logic [OWNER_W-1:0]   data;
    } own_wr_t;

endpackage

`default_nettype wire

// ----- rtl/core/fa_ram.sv -----
`default_nettype none

// Simple dual-port RAM, registered read, write-through on same address
module fa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; a write to the same address in this cycle is passed through
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/fa_ctrl.sv -----
`default_nettype none

// Allocator state (frame count, stack depth, valid bits) and request execution
module fa_ctrl import fa_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CNT_W-1:0]    cfg_count,
    input  logic                commit,
    input  action_t             act,
    input  logic [FRAME_W-1:0]  frame,
    input  logic [OWNER_W-1:0]  tag,
    input  logic [FRAME_W-1:0]  stk_rd,
    input  logic [OWNER_W-1:0]  own_rd,
    output res_t                res,
    output stk_wr_t             stk_wr,
    output own_wr_t             own_wr,
    output logic [CNT_W-1:0]    depth_next
);

    logic [CNT_W-1:0]      frame_count_reg;
    logic [CNT_W-1:0]      depth_reg;
    logic [MAX_FRAMES-1:0] stk_vld_reg;
    logic [MAX_FRAMES-1:0] stk_vld_next;
    logic [MAX_FRAMES-1:0] own_vld_reg;
    logic [MAX_FRAMES-1:0] own_vld_next;

    logic [CNT_W-1:0]      n_eff;
    logic [CNT_W-1:0]      n_cfg;
    logic [CNT_W-1:0]      depth_after;
    logic [CNT_W-1:0]      top_idx;
    logic [FRAME_W-1:0]    pop_frame;
    logic                  in_range;
    logic                  do_pop;
    logic                  do_push;
    logic                  own_set;

    // Effective frame count, bounded by the index space
    assign n_eff = (frame_count_reg > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                           : frame_count_reg;
    assign n_cfg = (cfg_count > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : cfg_count;

    assign in_range = ({1'b0, frame} < n_eff);

    // Top of stack: an entry never pushed since init holds n-1-i
    assign top_idx   = depth_reg - CNT_W'(1);
    assign pop_frame = stk_vld_reg[top_idx[FRAME_W-1:0]] ? stk_rd
                                                         : FRAME_W'(n_eff - depth_reg);

    // Request decode
    always_comb
    begin
        res     = '0;
        do_pop  = 1'b0;
        do_push = 1'b0;
        unique case (act)
            ACT_ALLOC:
            begin
                if ((depth_reg == '0) || (depth_reg > n_eff))
                begin
                    res.status = ST_NO_FREE;
                end
                else
                begin
                    do_pop            = 1'b1;
                    res.granted_frame = pop_frame;
                end
            end
            ACT_FREE:
            begin
                if (!in_range)
                begin
                    res.status = ST_RANGE;
                end
                else if (!own_vld_reg[frame] || (depth_reg >= n_eff))
                begin
                    res.status = ST_NOT_ALLOC;
                end
                else
                begin
                    do_push = 1'b1;
                end
            end
            ACT_QUERY:
            begin
                if (!in_range)
                begin
                    res.status = ST_RANGE;
                end
                else if (own_vld_reg[frame])
                begin
                    res.owner_out     = own_rd;
                    res.owner_present = 1'b1;
                end
            end
            ACT_NOP:
            begin
                res.status = ST_OK;
            end
            default:
            begin
                res.status = ST_OK;
            end
        endcase

        own_set = do_pop && ({1'b0, pop_frame} < n_eff);

        if (do_pop)
        begin
            depth_after = depth_reg - CNT_W'(1);
        end
        else if (do_push)
        begin
            depth_after = depth_reg + CNT_W'(1);
        end
        else
        begin
            depth_after = depth_reg;
        end
        res.free_available = (depth_after != '0);
    end

    // Memory write commands
    always_comb
    begin
        stk_wr.en   = commit && do_push;
        stk_wr.addr = depth_reg[FRAME_W-1:0];
        stk_wr.data = frame;
        own_wr.en   = commit && own_set;
        own_wr.addr = pop_frame;
        own_wr.data = tag;
    end

    // Next-state values
    always_comb
    begin
        stk_vld_next = stk_vld_reg;
        own_vld_next = own_vld_reg;
        if (cfg_we)
        begin
            depth_next   = n_cfg;
            stk_vld_next = '0;
            own_vld_next = '0;
        end
        else if (commit)
        begin
            depth_next = depth_after;
            if (do_push)
            begin
                stk_vld_next[depth_reg[FRAME_W-1:0]] = 1'b1;
                own_vld_next[frame]                  = 1'b0;
            end
            if (own_set)
            begin
                own_vld_next[pop_frame] = 1'b1;
            end
        end
        else
        begin
            depth_next = depth_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= CNT_W'(MAX_FRAMES);
            depth_reg       <= CNT_W'(MAX_FRAMES);
            stk_vld_reg     <= '0;
            own_vld_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                frame_count_reg <= cfg_count;
            end
            depth_reg   <= depth_next;
            stk_vld_reg <= stk_vld_next;
            own_vld_reg <= own_vld_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/frame_allocator_with_owner_table.sv -----
`default_nettype none

// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_ready    action, frame_index, owner_tag
// out       out  out_valid / out_ready  status, granted_frame, owner_out,
//                                       owner_present, free_available
// cfg       in   cfg_valid / cfg_ready  frame_count
//
// One request per cycle when the output is not stalled; each request has its
// memory read at the accepting edge, then executes into the output register.
// Stack top and owner entries written by one request are forwarded to the next
// through the RAM write-through path.
// Reset and frame_count writes reinitialize without a clearing pass.
// A stalled output register holds the execute stage, which holds the input.

module frame_allocator_with_owner_table import fa_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          action,
    input  logic [FRAME_W-1:0]  frame_index,
    input  logic [OWNER_W-1:0]  owner_tag,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [FRAME_W-1:0]  granted_frame,
    output logic [OWNER_W-1:0]  owner_out,
    output logic                owner_present,
    output logic                free_available,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CNT_W-1:0]    frame_count
);

    logic                s1_valid_reg;
    action_t             s1_action_reg;
    logic [FRAME_W-1:0]  s1_frame_reg;
    logic [OWNER_W-1:0]  s1_tag_reg;

    logic                out_valid_reg;
    res_t                out_res_reg;

    logic                in_accept;
    logic                cfg_we;
    logic                s1_adv;
    res_t                res;
    stk_wr_t             stk_wr;
    own_wr_t             own_wr;
    logic [CNT_W-1:0]    depth_next;
    logic [CNT_W-1:0]    pop_addr;
    logic [FRAME_W-1:0]  stk_rd;
    logic [OWNER_W-1:0]  own_rd;

    // Handshakes
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Pop address follows the depth left by the request ahead
    assign pop_addr = depth_next - CNT_W'(1);

    fa_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (MAX_FRAMES)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_wr.en),
        .waddr (stk_wr.addr),
        .wdata (stk_wr.data),
        .re    (in_accept),
        .raddr (pop_addr[FRAME_W-1:0]),
        .rdata (stk_rd)
    );

    fa_ram #(
        .WIDTH (OWNER_W),
        .DEPTH (MAX_FRAMES)
    ) u_own_ram (
        .clk   (clk),
        .we    (own_wr.en),
        .waddr (own_wr.addr),
        .wdata (own_wr.data),
        .re    (in_accept),
        .raddr (frame_index),
        .rdata (own_rd)
    );

    fa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_count  (frame_count),
        .commit     (s1_adv),
        .act        (s1_action_reg),
        .frame      (s1_frame_reg),
        .tag        (s1_tag_reg),
        .stk_rd     (stk_rd),
        .own_rd     (own_rd),
        .res        (res),
        .stk_wr     (stk_wr),
        .own_wr     (own_wr),
        .depth_next (depth_next)
    );

    // Execute stage and output register valid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg <= action_t'(action);
            s1_frame_reg  <= frame_index;
            s1_tag_reg    <= owner_tag;
        end
        if (s1_adv)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_res_reg.status;
    assign granted_frame  = out_res_reg.granted_frame;
    assign owner_out      = out_res_reg.owner_out;
    assign owner_present  = out_res_reg.owner_present;
    assign free_available = out_res_reg.free_available;

endmodule

`default_nettype wire

// ----- rtl/core/fa_sva.sv -----
`default_nettype none

// Port-level checks for the frame allocator
module fa_sva import fa_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [1:0]          status,
    input  logic [FRAME_W-1:0]  granted_frame,
    input  logic [OWNER_W-1:0]  owner_out,
    input  logic                owner_present,
    input  logic                free_available
);

    // Failed allocate only happens with an empty stack
    a_no_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_NO_FREE)) |-> !free_available)
        else $error("no-free status with free frames left");

    // An owner is only reported on a good query
    a_owner_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && owner_present) |-> (status == ST_OK))
        else $error("owner reported with error status");

    // No owner means a zero tag
    a_owner_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !owner_present) |-> (owner_out == '0))
        else $error("owner tag without owner");

    // Errored transactions carry no grant and no owner
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> ((granted_frame == '0) && !owner_present))
        else $error("payload on errored transaction");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)
                                       && $stable(granted_frame) && $stable(owner_out)))
        else $error("stalled result changed");

endmodule

bind frame_allocator_with_owner_table fa_sva u_fa_sva (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .granted_frame  (granted_frame),
    .owner_out      (owner_out),
    .owner_present  (owner_present),
    .free_available (free_available)
);

`default_nettype wire
